FILE: design/psu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_pkg
// Shared widths, limits, helper functions and types for the packed symbol
// unpacker.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TotalW   = 25;
  localparam int unsigned SymW     = 5;
  localparam int unsigned BufW     = 12;
  localparam int unsigned CntW     = 4;
  localparam int unsigned CfgW     = 3;
  localparam int unsigned ResultsN = 4;
  localparam int unsigned NumW     = 3;
  localparam int unsigned IdxW     = 2;

  localparam logic [TotalW-1:0] MaxSymbols = 25'd16777216;
  localparam logic [CfgW-1:0]   WidthMin   = 3'd2;
  localparam logic [CfgW-1:0]   WidthMax   = 3'd5;
  localparam logic [CfgW-1:0]   WidthReset = 3'd2;

  // Accepted input item.
  typedef struct packed {
    logic [ByteW-1:0]  packed_byte;
    logic              sequence_start;
    logic [TotalW-1:0] symbol_total;
  } in_item_t;

  // Group of symbols produced by one byte.
  typedef struct packed {
    logic [ResultsN-1:0][SymW-1:0] sym;
    logic [NumW-1:0]               count;
    logic                          last;
  } batch_t;

  // Clamp the configured width into the supported range.
  function automatic logic [CfgW-1:0] eff_width(input logic [CfgW-1:0] cfg);
    logic [CfgW-1:0] w;
    w = cfg;
    if (cfg < WidthMin) w = WidthMin;
    if (cfg > WidthMax) w = WidthMax;
    return w;
  endfunction

  // Symbol mask for a width of two to five bits.
  function automatic logic [SymW-1:0] sym_mask(input logic [CfgW-1:0] w);
    logic [SymW-1:0] m;
    case (w)
      3'd2:    m = 5'd3;
      3'd3:    m = 5'd7;
      3'd4:    m = 5'd15;
      default: m = 5'd31;
    endcase
    return m;
  endfunction

endpackage

FILE: design/psu_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_in_stage
// Input register: holds one accepted byte with its sequence fields until the
// unpack stage takes it.
// ----------------------------------------------------------------------------
module psu_in_stage import psu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  packed_byte_i,
  input  logic              sequence_start_i,
  input  logic [TotalW-1:0] symbol_total_i,
  output in_item_t          item_o,
  output logic              item_valid_o,
  input  logic              item_take_i
);

  logic     full_q, full_d;
  in_item_t item_q;
  logic     in_xfer;

  // The register is free when empty or when its item leaves this cycle.
  assign in_ready_o = !full_q || item_take_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    full_d = full_q;
    if (in_xfer) begin
      full_d = 1'b1;
    end else if (item_take_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // Payload capture on each input transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.packed_byte    <= packed_byte_i;
      item_q.sequence_start <= sequence_start_i;
      item_q.symbol_total   <= symbol_total_i;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = full_q;

endmodule

FILE: design/psu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_core
// Unpack stage: merges one byte into the bit buffer, cuts out every whole
// symbol still owed (up to four) and updates the sequence state.
// ----------------------------------------------------------------------------
module psu_core import psu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CfgW-1:0] width_i,
  input  in_item_t        item_i,
  input  logic            item_valid_i,
  output logic            item_take_o,
  input  logic            batch_free_i,
  output batch_t          batch_o,
  output logic            batch_load_o
);

  logic [BufW-1:0]   buf_q, buf_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TotalW-1:0] rem_q, rem_d;

  logic [BufW-1:0]   buf_base, nbuf;
  logic [BufW-1:0]   sh1, sh2, sh3;
  logic [CntW-1:0]   cnt_base, ncnt;
  logic [TotalW-1:0] rem_base, rem_next;
  logic [SymW-1:0]   w1, w2, w3, w4, ncnt_x, used;
  logic [NumW-1:0]   avail, num;
  logic [SymW-1:0]   mask;

  assign item_take_o  = item_valid_i && batch_free_i;
  assign batch_load_o = item_take_o;

  // Multiples of the symbol width for the symbol count and the shifts.
  assign w1   = {2'b00, width_i};
  assign w2   = w1 << 1;
  assign w3   = w1 + w2;
  assign w4   = w1 << 2;
  assign mask = sym_mask(width_i);

  // Sequence start clears the buffer and loads the saturated total.
  always_comb begin
    if (item_i.sequence_start) begin
      buf_base = '0;
      cnt_base = '0;
      rem_base = item_i.symbol_total[TotalW-1] ? MaxSymbols : item_i.symbol_total;
    end else begin
      buf_base = buf_q;
      cnt_base = cnt_q;
      rem_base = rem_q;
    end
  end

  // Append the byte above the bits already buffered.
  assign nbuf   = buf_base | ({{(BufW-ByteW){1'b0}}, item_i.packed_byte} << cnt_base[2:0]);
  assign ncnt   = cnt_base + 4'd8;
  assign ncnt_x = {1'b0, ncnt};

  // Whole symbols available, limited to four and to the symbols owed.
  always_comb begin
    if (ncnt_x >= w4) begin
      avail = 3'd4;
    end else if (ncnt_x >= w3) begin
      avail = 3'd3;
    end else if (ncnt_x >= w2) begin
      avail = 3'd2;
    end else if (ncnt_x >= w1) begin
      avail = 3'd1;
    end else begin
      avail = 3'd0;
    end
    if (rem_base < {{(TotalW-NumW){1'b0}}, avail}) begin
      num = rem_base[NumW-1:0];
    end else begin
      num = avail;
    end
  end

  // Bits consumed by the emitted symbols.
  always_comb begin
    case (num)
      3'd0:    used = '0;
      3'd1:    used = w1;
      3'd2:    used = w2;
      3'd3:    used = w3;
      default: used = w4;
    endcase
  end

  assign rem_next = rem_base - {{(TotalW-NumW){1'b0}}, num};

  // Buffer shifted to each symbol position.
  assign sh1 = nbuf >> w1;
  assign sh2 = nbuf >> w2;
  assign sh3 = nbuf >> w3;

  // Result batch: symbols at successive width offsets.
  always_comb begin
    batch_o.sym[0] = nbuf[SymW-1:0] & mask;
    batch_o.sym[1] = sh1[SymW-1:0] & mask;
    batch_o.sym[2] = sh2[SymW-1:0] & mask;
    batch_o.sym[3] = sh3[SymW-1:0] & mask;
    batch_o.last   = (rem_base != '0) && (rem_next == '0);
    batch_o.count  = (rem_base == '0) ? 3'd0 : num;
  end

  // Next sequence state.
  always_comb begin
    buf_d = buf_base;
    cnt_d = cnt_base;
    rem_d = rem_base;
    if (rem_base != '0) begin
      rem_d = rem_next;
      if (rem_next == '0) begin
        buf_d = '0;
        cnt_d = '0;
      end else begin
        buf_d = nbuf >> used;
        cnt_d = ncnt - used[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
      rem_q <= '0;
    end else if (item_take_o) begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      rem_q <= rem_d;
    end
  end

endmodule

FILE: design/psu_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_out_queue
// Result register: holds one batch of symbols and hands them out one per
// transfer, marking the final symbol of a sequence.
// ----------------------------------------------------------------------------
module psu_out_queue import psu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  batch_t          batch_i,
  input  logic            batch_load_i,
  output logic            batch_free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [SymW-1:0] symbol_o,
  output logic            last_symbol_o
);

  logic [ResultsN-1:0][SymW-1:0] sym_q;
  logic                          last_q;
  logic [NumW-1:0]               cnt_q, cnt_d;
  logic [IdxW-1:0]               idx_q, idx_d;
  logic                          out_xfer;

  assign out_valid_o   = (cnt_q != '0);
  assign out_xfer      = out_valid_o && out_ready_i;
  assign symbol_o      = sym_q[idx_q];
  assign last_symbol_o = last_q && (cnt_q == 3'd1);

  // Free when empty or when the final symbol is taken this cycle.
  assign batch_free_o = (cnt_q == '0) || ((cnt_q == 3'd1) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (batch_load_i) begin
      cnt_d = batch_i.count;
      idx_d = '0;
    end else if (out_xfer) begin
      cnt_d = cnt_q - 3'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Batch payload capture.
  always_ff @(posedge clk_i) begin
    if (batch_load_i) begin
      sym_q  <= batch_i.sym;
      last_q <= batch_i.last;
    end
  end

endmodule

FILE: design/packed_symbol_unpacker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_symbol_unpacker_unit
// Unpacks symbols of two to five bits, packed LSB first in a byte stream,
// and marks the final symbol of each sequence.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  cfg       in         cfg_valid_i / cfg_ready_o  cfg_bits_per_symbol_i
//  in        in         in_valid_i / in_ready_o    packed_byte_i, sequence_start_i,
//                                                  symbol_total_i
//  out       out        out_valid_o / out_ready_i  symbol_o, last_symbol_o
//
// A byte is registered on transfer, then unpacked into a result register once
// that register is free, and its symbols leave one per cycle while out_ready_i
// is high. A byte yields up to four symbols, and the result register takes
// no new byte before the last of them has left through the single output port.
// Reset clears the bit buffer, the counts and the width (back to two bits).
// A stall at the output holds the result register and then the input register.
// ----------------------------------------------------------------------------
module packed_symbol_unpacker_unit import psu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgW-1:0]   cfg_bits_per_symbol_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  packed_byte_i,
  input  logic              sequence_start_i,
  input  logic [TotalW-1:0] symbol_total_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SymW-1:0]   symbol_o,
  output logic              last_symbol_o
);

  logic [CfgW-1:0] bps_q;
  logic [CfgW-1:0] width;
  in_item_t        item;
  logic            item_valid, item_take;
  batch_t          batch;
  logic            batch_load, batch_free;

  // Symbol width register, always ready for a transfer.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q <= WidthReset;
    end else if (cfg_valid_i) begin
      bps_q <= cfg_bits_per_symbol_i;
    end
  end

  assign width = eff_width(bps_q);

  psu_in_stage u_in_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .packed_byte_i    (packed_byte_i),
    .sequence_start_i (sequence_start_i),
    .symbol_total_i   (symbol_total_i),
    .item_o           (item),
    .item_valid_o     (item_valid),
    .item_take_i      (item_take)
  );

  psu_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .width_i      (width),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .batch_free_i (batch_free),
    .batch_o      (batch),
    .batch_load_o (batch_load)
  );

  psu_out_queue u_out_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .batch_i       (batch),
    .batch_load_i  (batch_load),
    .batch_free_o  (batch_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_o      (symbol_o),
    .last_symbol_o (last_symbol_o)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packed symbol unpacker. A directed table covers
// the corner cases of the symbol width and the sequence total. Random
// sequences follow, most of them well formed and the rest short, overlong or
// empty. Every symbol that leaves the block is compared in order with the
// symbols predicted from each accepted byte. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module testbench;
  import psu_pkg::*;

  localparam int RandItems   = 100;
  localparam int DrainCycles = 10;

  // One unpacked symbol as it should leave the block.
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
  } sym_result_t;

  // One row of stimulus: either a width write or a byte, with the symbols
  // typed in by hand where they are obvious.
  typedef struct {
    bit                            set_width;
    logic [CfgW-1:0]               width_cfg;
    logic [ByteW-1:0]              pbyte;
    logic                          start;
    logic [TotalW-1:0]             total;
    bit                            typed;
    int                            n;
    logic [ResultsN-1:0][SymW-1:0] syms;
    logic [ResultsN-1:0]           lasts;
  } stim_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CfgW-1:0]   cfg_width = WidthReset;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [ByteW-1:0]  pbyte     = '0;
  logic              seq_start = 1'b0;
  logic [TotalW-1:0] sym_total = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SymW-1:0]   symbol;
  logic              last_symbol;

  // Predicted state of the unpacker and the symbols still owed by it.
  logic [CfgW-1:0]   exp_width_cfg = WidthReset;
  logic [BufW-1:0]   exp_buf       = '0;
  logic [CntW-1:0]   exp_count     = '0;
  logic [TotalW-1:0] exp_owed      = '0;
  sym_result_t       pending_symbols[$];

  int errors     = 0;
  int ready_hold = 0;
  int calm_left  = 0;

  packed_symbol_unpacker_unit dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_bits_per_symbol_i (cfg_width),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .packed_byte_i         (pbyte),
    .sequence_start_i      (seq_start),
    .symbol_total_i        (sym_total),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .symbol_o              (symbol),
    .last_symbol_o         (last_symbol)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard limit on the run, far above the slowest legal run.
  initial begin
    #4_000_000;
    $display("%0t: timeout with %0d symbols outstanding", $time, pending_symbols.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Widths outside two to five bits are pinned to the nearest end.
  function automatic logic [CfgW-1:0] used_width(input logic [CfgW-1:0] cfg);
    return (cfg < WidthMin) ? WidthMin : ((cfg > WidthMax) ? WidthMax : cfg);
  endfunction

  // Appends one byte to the predicted bit buffer and emits the whole symbols
  // it completes. Returns 0 when the byte is dropped because nothing is owed.
  function automatic bit unpack_byte(input logic [ByteW-1:0] b, input logic start,
                                     input logic [TotalW-1:0] total, input bit record);
    logic [CfgW-1:0] w;
    logic [SymW-1:0] mask;
    logic [14:0]     shifted;
    sym_result_t     r;
    int              n;
    w    = used_width(exp_width_cfg);
    mask = 5'b11111 >> (3'd5 - w);
    n    = 0;
    if (start) begin
      exp_owed  = (total > MaxSymbols) ? MaxSymbols : total;
      exp_buf   = '0;
      exp_count = '0;
    end
    if (exp_owed == 0) return 1'b0;
    shifted   = {7'd0, b} << exp_count[2:0];
    exp_buf   = exp_buf | shifted[BufW-1:0];
    exp_count = exp_count + 4'd8;
    while (n < ResultsN && exp_owed != 0 && exp_count >= w) begin
      r.symbol  = exp_buf[SymW-1:0] & mask;
      exp_buf   = exp_buf >> w;
      exp_count = exp_count - w;
      exp_owed  = exp_owed - 1'b1;
      r.last    = (exp_owed == 0);
      if (record) pending_symbols.push_back(r);
      n++;
    end
    // Padding bits after the final symbol are thrown away.
    if (exp_owed == 0) begin
      exp_buf   = '0;
      exp_count = '0;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t byte_row(input logic [ByteW-1:0] b, input logic s,
                                         input logic [TotalW-1:0] t);
    stim_row_t r;
    r       = '{default: 0};
    r.pbyte = b;
    r.start = s;
    r.total = t;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [ByteW-1:0] b, input logic s,
                                          input logic [TotalW-1:0] t, input int n,
                                          input logic [ResultsN-1:0][SymW-1:0] syms,
                                          input logic [ResultsN-1:0] lasts);
    stim_row_t r;
    r       = byte_row(b, s, t);
    r.typed = 1'b1;
    r.n     = n;
    r.syms  = syms;
    r.lasts = lasts;
    return r;
  endfunction

  function automatic stim_row_t width_row(input logic [CfgW-1:0] v);
    stim_row_t r;
    r           = '{default: 0};
    r.set_width = 1'b1;
    r.width_cfg = v;
    return r;
  endfunction

  // Drives one byte after a random gap and records its symbols on transfer.
  // Valid stays high after the transfer so back-to-back bytes need no toggle.
  task automatic send_item(input stim_row_t row, output bit taken);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(8, 20);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    pbyte     <= row.pbyte;
    seq_start <= row.start;
    sym_total <= row.total;
    do @(posedge clk); while (!in_ready);
    taken = unpack_byte(row.pbyte, row.start, row.total, !row.typed);
    if (row.typed) begin
      for (int i = 0; i < row.n; i++) begin
        pending_symbols.push_back('{symbol: row.syms[i], last: row.lasts[i]});
      end
    end
  endtask

  // Holds the sender until every owed symbol is out and the pipe is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_symbols.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_width(input logic [CfgW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_width <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    exp_width_cfg = value;
  endtask

  // Output stalls: short and long stalls between stretches of steady ready.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= idle_len() + 1;
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 40);
    end
  end

  // Compare every output transfer with the oldest predicted symbol.
  always @(posedge clk) begin : result_check
    sym_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_symbols.size() == 0) begin
        $display("%0t: unexpected symbol %0d last %0b", $time, symbol, last_symbol);
        errors++;
      end else begin
        want = pending_symbols.pop_front();
        if (symbol !== want.symbol) begin
          $display("%0t: symbol expected %0d, got %0d", $time, want.symbol, symbol);
          errors++;
        end
        if (last_symbol !== want.last) begin
          $display("%0t: last_symbol expected %0b, got %0b", $time, want.last, last_symbol);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t         rows[$];
    stim_row_t         row;
    logic [CfgW-1:0]   w;
    logic [TotalW-1:0] total;
    int                kind;
    int                full;
    int                nbytes;
    int                consumed;
    bit                taken;

    // Two-bit width out of reset: a full byte, then bytes with nothing owed.
    rows.push_back(typed_row(8'hE4, 1'b1, 25'd4, 4, {5'd3, 5'd2, 5'd1, 5'd0}, 4'b1000));
    rows.push_back(typed_row(8'hFF, 1'b0, 25'd0, 0, '0, '0));
    rows.push_back(typed_row(8'h00, 1'b1, 25'd0, 0, '0, '0));
    rows.push_back(typed_row(8'hFF, 1'b0, 25'h1FFFFFF, 0, '0, '0));
    // Total spread over two bytes, the second ending the sequence early.
    rows.push_back(typed_row(8'h1B, 1'b1, 25'd6, 4, {5'd0, 5'd1, 5'd2, 5'd3}, 4'b0000));
    rows.push_back(typed_row(8'h80, 1'b0, 25'd0, 2, {5'd0, 5'd0, 5'd0, 5'd0}, 4'b0010));
    // Three bits: symbols straddle bytes, a trailing byte is dropped.
    rows.push_back(width_row(3'd3));
    rows.push_back(byte_row(8'hFF, 1'b1, 25'd5));
    rows.push_back(byte_row(8'hA5, 1'b0, 25'd0));
    rows.push_back(byte_row(8'h3C, 1'b0, 25'd0));
    // Four bits: single symbol with padding, then a saturated total.
    rows.push_back(width_row(3'd4));
    rows.push_back(typed_row(8'hFF, 1'b1, 25'd1, 1, {5'd0, 5'd0, 5'd0, 5'd15}, 4'b0001));
    rows.push_back(byte_row(8'h00, 1'b1, 25'd16777217));
    rows.push_back(byte_row(8'hFF, 1'b0, 25'd0));
    // Five bits: a maximal total is abandoned by a new sequence.
    rows.push_back(width_row(3'd5));
    rows.push_back(byte_row(8'hFF, 1'b1, 25'h1FFFFFF));
    rows.push_back(byte_row(8'h5A, 1'b1, 25'd3));
    rows.push_back(byte_row(8'hC3, 1'b0, 25'd0));
    // Widths outside the range are pinned to two or five bits.
    rows.push_back(width_row(3'd0));
    rows.push_back(typed_row(8'h0F, 1'b1, 25'd2, 2, {5'd0, 5'd0, 5'd3, 5'd3}, 4'b0010));
    rows.push_back(width_row(3'd7));
    rows.push_back(byte_row(8'h55, 1'b1, 25'd2));
    rows.push_back(byte_row(8'hAA, 1'b0, 25'h0AAAAAA));
    rows.push_back(width_row(3'd1));
    rows.push_back(byte_row(8'h96, 1'b1, 25'd3));
    rows.push_back(width_row(3'd6));
    rows.push_back(byte_row(8'h12, 1'b1, MaxSymbols));
    rows.push_back(byte_row(8'h34, 1'b0, 25'h1555555));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].set_width) begin
        wait_idle();
        write_width(rows[i].width_cfg);
      end else begin
        send_item(rows[i], taken);
      end
    end

    // Random phases: a new width, then a few sequences at that width.
    consumed = 0;
    while (consumed < RandItems) begin
      wait_idle();
      write_width(CfgW'($urandom_range(0, 7)));
      w = used_width(exp_width_cfg);
      repeat ($urandom_range(2, 5)) begin
        if (consumed < RandItems) begin
          kind = $urandom_range(0, 11);
          case (kind)
            0:       total = TotalW'($urandom);
            1:       total = '0;
            default: total = TotalW'($urandom_range(1, 24));
          endcase
          full = (int'(total) * int'(w) + 7) / 8;
          case (kind)
            0, 1:    nbytes = $urandom_range(1, 3);
            2:       nbytes = $urandom_range(1, (full > 1) ? full - 1 : 1);
            3:       nbytes = full + $urandom_range(1, 2);
            default: nbytes = full;
          endcase
          for (int b = 0; b < nbytes; b++) begin
            row = byte_row(ByteW'($urandom), b == 0, (b == 0) ? total : TotalW'($urandom));
            send_item(row, taken);
            if (taken) consumed++;
          end
          if ($urandom_range(0, 15) == 0) wait_idle();
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/psu_pkg.sv
design/psu_in_stage.sv
design/psu_core.sv
design/psu_out_queue.sv
design/packed_symbol_unpacker_unit.sv
test/testbench.sv
